@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the display counter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Whenever ante holds, cons must hold on the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Whenever ante holds, cons must hold on the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/dbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button counter display package
// Widths, display constants, pipeline types and decode functions.
// ----------------------------------------------------------------------------
package dbc_pkg;

   localparam int PIN_W    = 8;
   localparam int HIST_W   = 13;
   localparam int COUNT_W  = 10;
   localparam int SEG_W    = 8;
   localparam int SEL_W    = 8;
   localparam int IDX_W    = 2;
   localparam int REM_W    = 7;
   localparam int DIGIT_W  = 4;

   localparam logic [15:0]        FORCED_TOP    = 16'hE000;
   localparam logic [15:0]        PRESS_PATTERN = 16'hF000;
   localparam logic [COUNT_W:0]   COUNT_MAX     = 11'd1023;
   localparam logic [COUNT_W-1:0] COUNT_RESTART = 10'h001;
   localparam logic [COUNT_W-1:0] THOUSAND      = 10'd1000;
   localparam logic [COUNT_W-1:0] LIMIT_HUNDRED = 10'd100;
   localparam logic [COUNT_W-1:0] LIMIT_TEN     = 10'd10;
   localparam logic [SEG_W-1:0]   BLANK_CODE    = 8'hFF;
   localparam int                 HUNDRED       = 100;
   localparam int                 TEN           = 10;

   localparam logic [IDX_W-1:0] POS_ONES      = 2'd0;
   localparam logic [IDX_W-1:0] POS_TENS      = 2'd1;
   localparam logic [IDX_W-1:0] POS_HUNDREDS  = 2'd2;
   localparam logic [IDX_W-1:0] POS_THOUSANDS = 2'd3;

   // Payload of the merge stage: one beat after the lanes have spoken.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [IDX_W-1:0]   index;
      logic [PIN_W-1:0]   mask;
   } stage_type;

   // Result beat as it leaves on the response channel.
   typedef struct packed {
      logic [SEG_W-1:0]   segment_code;
      logic [SEL_W-1:0]   digit_code;
      logic [IDX_W-1:0]   digit_index;
      logic [COUNT_W-1:0] count_value;
      logic [PIN_W-1:0]   press_mask;
   } rsp_type;

   // Active-low segments a..g plus point.
   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] code;
      unique case (digit)
         4'd0:    code = 8'h03;
         4'd1:    code = 8'h9F;
         4'd2:    code = 8'h25;
         4'd3:    code = 8'h0D;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h49;
         4'd6:    code = 8'h41;
         4'd7:    code = 8'h1F;
         4'd8:    code = 8'h01;
         4'd9:    code = 8'h09;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

   function automatic logic [SEL_W-1:0] select_of(input logic [IDX_W-1:0] index);
      logic [SEL_W-1:0] code;
      unique case (index)
         POS_ONES:      code = 8'h00;
         POS_TENS:      code = 8'h10;
         POS_HUNDREDS:  code = 8'h30;
         POS_THOUSANDS: code = 8'h40;
         default:       code = 8'h00;
      endcase
      return code;
   endfunction

   // Hundreds digit of a value below one thousand, by a row of compares.
   function automatic logic [DIGIT_W-1:0] hundreds_of(input logic [COUNT_W-1:0] value);
      logic [DIGIT_W-1:0] d;
      d = '0;
      for (int k = 1; k <= 9; k++) begin
         if (value >= COUNT_W'(k * HUNDRED)) begin
            d = d + 4'd1;
         end
      end
      return d;
   endfunction

   // Tens digit of a value below one hundred.
   function automatic logic [DIGIT_W-1:0] tens_of(input logic [REM_W-1:0] value);
      logic [DIGIT_W-1:0] d;
      d = '0;
      for (int k = 1; k <= 9; k++) begin
         if (value >= REM_W'(k * TEN)) begin
            d = d + 4'd1;
         end
      end
      return d;
   endfunction

endpackage

@@ design/dbc_if.sv @@
// ----------------------------------------------------------------------------
// Button counter display channels
// Valid/ready channels for the sample beats and the display beats.
// ----------------------------------------------------------------------------
interface dbc_req_if;
   import dbc_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface

interface dbc_rsp_if;
   import dbc_pkg::*;

   logic               valid;
   logic               ready;
   logic [SEG_W-1:0]   segment_code;
   logic [SEL_W-1:0]   digit_code;
   logic [IDX_W-1:0]   digit_index;
   logic [COUNT_W-1:0] count_value;
   logic [PIN_W-1:0]   press_mask;

   modport source (output valid, output segment_code, output digit_code,
                   output digit_index, output count_value, output press_mask,
                   input ready);
   modport sink   (input valid, input segment_code, input digit_code,
                   input digit_index, input count_value, input press_mask,
                   output ready);
endinterface

@@ design/debounced_button_counter_display.sv @@
// ----------------------------------------------------------------------------
// Debounced button counter display
// Eight debounced buttons drive a wrapping count shown on four muxed digits.
// ----------------------------------------------------------------------------
// The request channel carries one beat per sample tick: pin_levels holds the
// raw active-low button levels, and bits at or above NUM_BUTTONS are ignored.
// The response channel returns exactly one beat per request beat, in order.
// Each response beat holds the count after that tick's presses, the buttons
// whose press was recognized on that tick, and one display digit with its
// segment code and select byte; the digit position rotates 0, 1, 2, 3.
//
// Throughput is one beat per cycle while the receiver takes beats. All
// debounce lanes work on the same beat side by side, and the count update
// is one add and compare in the merge stage. A response appears three
// register stages after its request (merge, decimal split, segment decode).
//
// The pipeline moves as a whole. When the receiver holds ready low with a
// beat waiting, every stage holds and req_ch.ready drops in the same cycle,
// so no beat is lost or repeated. Synchronous reset clears all debounce
// histories, the count and the digit pointer, and empties the pipeline.
// ----------------------------------------------------------------------------
module debounced_button_counter_display #(
   parameter int NUM_BUTTONS = 8
) (
   input  logic      clock,
   input  logic      reset,
   dbc_req_if.sink   req_ch,
   dbc_rsp_if.source rsp_ch
);
   import dbc_pkg::*;

   logic             advance;
   logic             accept;
   logic [PIN_W-1:0] press_vec;
   logic             merge_valid;
   stage_type        merge_stage;
   logic             rsp_valid;
   rsp_type          rsp_beat;

   // Every stage advances unless a finished beat is waiting on the receiver.
   assign advance      = !rsp_valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   // One debounce lane per button; pins beyond the configured count never
   // report a press.
   for (genvar k = 0; k < PIN_W; k++) begin : g_lane
      if (k < NUM_BUTTONS) begin : g_used
         dbc_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .accept (accept),
            .sample (req_ch.pin_levels[k]),
            .press  (press_vec[k])
         );
      end else begin : g_unused
         assign press_vec[k] = 1'b0;
      end
   end

   // The lanes' presses are folded into the running count here.
   dbc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (advance),
      .press_vec (press_vec),
      .out_valid (merge_valid),
      .out_stage (merge_stage)
   );

   // Decimal split, blanking of leading zeros and segment decode.
   dbc_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (merge_valid),
      .in_stage  (merge_stage),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_beat)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.segment_code = rsp_beat.segment_code;
   assign rsp_ch.digit_code   = rsp_beat.digit_code;
   assign rsp_ch.digit_index  = rsp_beat.digit_index;
   assign rsp_ch.count_value  = rsp_beat.count_value;
   assign rsp_ch.press_mask   = rsp_beat.press_mask;

endmodule

@@ design/dbc_lane.sv @@
// ----------------------------------------------------------------------------
// Button debounce lane
// Thirteen-sample history for one button; flags a press once per hold.
// ----------------------------------------------------------------------------
module dbc_lane (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic sample,
   output logic press
);
   import dbc_pkg::*;

   logic [HIST_W-1:0] hist_ff;
   logic [HIST_W-1:0] hist_in;

   assign hist_in = {hist_ff[HIST_W-2:0], sample};

   // One released sample followed by twelve pressed ones.
   assign press = ((16'(hist_in) | FORCED_TOP) == PRESS_PATTERN);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (accept) begin
         hist_ff <= hist_in;
      end
   end

endmodule

@@ design/dbc_merge.sv @@
// ----------------------------------------------------------------------------
// Lane merge stage
// Adds the lane presses to the count, applies the wrap, tags the digit slot.
// ----------------------------------------------------------------------------
module dbc_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    advance,
   input  logic [dbc_pkg::PIN_W-1:0] press_vec,
   output logic                    out_valid,
   output dbc_pkg::stage_type      out_stage
);
   import dbc_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [IDX_W-1:0]   ptr_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [PIN_W-1:0]   mask_ff;
   logic               valid_ff;
   logic [COUNT_W:0]   sum;

   // Button k weighs 2^k, so the press vector read as a number is the sum.
   assign sum      = {1'b0, count_ff} + (COUNT_W + 1)'(press_vec);
   assign count_in = (sum > COUNT_MAX) ? COUNT_RESTART : sum[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            ptr_ff   <= ptr_ff + 2'd1;
         end
         if (advance) begin
            valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         index_ff <= ptr_ff;
         mask_ff  <= press_vec;
      end
   end

   assign out_valid       = valid_ff;
   assign out_stage.count = count_ff;
   assign out_stage.index = index_ff;
   assign out_stage.mask  = mask_ff;

endmodule

@@ design/dbc_digits.sv @@
// ----------------------------------------------------------------------------
// Decimal split and segment decode
// Two registered stages: thousands and hundreds, then tens, ones and segments.
// ----------------------------------------------------------------------------
module dbc_digits (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  dbc_pkg::stage_type in_stage,
   output logic               out_valid,
   output dbc_pkg::rsp_type   out_rsp
);
   import dbc_pkg::*;

   typedef struct packed {
      stage_type          head;
      logic               d3;
      logic [DIGIT_W-1:0] d2;
      logic [REM_W-1:0]   r2;
   } split_type;

   split_type          split_ff;
   split_type          split_in;
   logic               split_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] below_k;
   logic [DIGIT_W-1:0] d1;
   logic [DIGIT_W-1:0] d0;
   logic [DIGIT_W-1:0] digit;
   logic               blank;

   // The count never reaches two thousand, so the thousands digit is one bit.
   always_comb begin
      split_in.head = in_stage;
      split_in.d3   = (in_stage.count >= THOUSAND);
      below_k       = split_in.d3 ? (in_stage.count - THOUSAND) : in_stage.count;
      split_in.d2   = hundreds_of(below_k);
      split_in.r2   = REM_W'(below_k - COUNT_W'(int'(split_in.d2) * HUNDRED));
   end

   always_comb begin
      d1 = tens_of(split_ff.r2);
      d0 = DIGIT_W'(split_ff.r2 - REM_W'(int'(d1) * TEN));
      unique case (split_ff.head.index)
         POS_ONES:      digit = d0;
         POS_TENS:      digit = d1;
         POS_HUNDREDS:  digit = split_ff.d2;
         POS_THOUSANDS: digit = DIGIT_W'(split_ff.d3);
         default:       digit = d0;
      endcase
      blank = ((split_ff.head.index == POS_THOUSANDS) && (split_ff.head.count < THOUSAND))
           || ((split_ff.head.index == POS_HUNDREDS)  && (split_ff.head.count < LIMIT_HUNDRED))
           || ((split_ff.head.index == POS_TENS)      && (split_ff.head.count < LIMIT_TEN));
      rsp_in.segment_code = blank ? BLANK_CODE : seg_of(digit);
      rsp_in.digit_code   = select_of(split_ff.head.index);
      rsp_in.digit_index  = split_ff.head.index;
      rsp_in.count_value  = split_ff.head.count;
      rsp_in.press_mask   = split_ff.head.mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         split_valid_ff <= in_valid;
         rsp_valid_ff   <= split_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         split_ff <= split_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

@@ design/dbc_checker.sv @@
// ----------------------------------------------------------------------------
// Button counter display checker
// Port-level checks on the response beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbc_checker #(
   parameter int NUM_BUTTONS = 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dbc_pkg::SEG_W-1:0]     segment_code,
   input logic [dbc_pkg::SEL_W-1:0]     digit_code,
   input logic [dbc_pkg::IDX_W-1:0]     digit_index,
   input logic [dbc_pkg::COUNT_W-1:0]   count_value,
   input logic [dbc_pkg::PIN_W-1:0]     press_mask
);
   import dbc_pkg::*;

   logic                             seen_ff;
   logic [IDX_W-1:0]                 last_idx_ff;
   logic                             rsp_fire;
   logic                             rsp_wait;
   logic [SEG_W+COUNT_W+IDX_W-1:0]   rsp_word;
   logic                             index_next;
   logic                             select_ok;
   logic                             top_digit_low;
   logic                             unused_quiet;

   assign rsp_fire = rsp_valid && rsp_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;
   assign rsp_word = {segment_code, count_value, digit_index};

   assign index_next = (digit_index == IDX_W'(last_idx_ff + 2'd1));

   assign select_ok = ((digit_index == POS_ONES)      && (digit_code == 8'h00))
                   || ((digit_index == POS_TENS)      && (digit_code == 8'h10))
                   || ((digit_index == POS_HUNDREDS)  && (digit_code == 8'h30))
                   || ((digit_index == POS_THOUSANDS) && (digit_code == 8'h40));

   assign top_digit_low = rsp_valid && (digit_index == POS_THOUSANDS)
                       && (count_value < THOUSAND);

   assign unused_quiet = ((16'(press_mask) >> NUM_BUTTONS) == 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         last_idx_ff <= '0;
      end else if (rsp_fire) begin
         seen_ff     <= 1'b1;
         last_idx_ff <= digit_index;
      end
   end

   // A waiting beat stays and keeps its segment code, count and digit index.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_word))

   // Successive beats show successive digit positions.
   `ASSERT_IMPLIES(a_idx_rotate, clock, reset, rsp_fire && seen_ff, index_next)

   // The select byte belongs to the digit position shown.
   `ASSERT_IMPLIES(a_select, clock, reset, rsp_valid, select_ok)

   // Below one thousand the leftmost digit is dark.
   `ASSERT_IMPLIES(a_blank_top, clock, reset, top_digit_low, segment_code == BLANK_CODE)

   // Buttons beyond the configured count never report a press.
   `ASSERT_IMPLIES(a_unused_pins, clock, reset, rsp_valid, unused_quiet)

endmodule

bind debounced_button_counter_display dbc_checker #(
   .NUM_BUTTONS (NUM_BUTTONS)
) u_dbc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .segment_code (rsp_ch.segment_code),
   .digit_code   (rsp_ch.digit_code),
   .digit_index  (rsp_ch.digit_index),
   .count_value  (rsp_ch.count_value),
   .press_mask   (rsp_ch.press_mask)
);
